// File: rtl/tdt_pkg.sv
// Shared constants and types for the totient trial-division unit.
package tdt_pkg;

   localparam int NUMBER_WIDTH_DEFAULT = 32;

   typedef struct packed {
      logic busy;
      logic done;
   } tdt_div_status_type;

endpackage

// File: rtl/tdt_divider.sv
// Restoring radix-2 divider, one quotient bit per cycle, shared by the sequencer.
module tdt_divider import tdt_pkg::*; #(
   parameter int WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [WIDTH-1:0]   dividend,
   input  logic [WIDTH-1:0]   divisor,
   output tdt_div_status_type status,
   output logic [WIDTH-1:0]   quotient,
   output logic [WIDTH-1:0]   remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH:0]   trial;
   logic [WIDTH:0]   diff;

   always_comb begin
      trial   = {rem_ff, quo_ff[WIDTH-1]};
      diff    = trial - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = trial[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = quo_ff;
   assign remainder   = rem_ff;

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> (!busy_ff && !done_ff))
      else $error("divider started while busy");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      start |-> (divisor != '0))
      else $error("divider started with zero divisor");

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff))
      else $error("divider done without a running division");

endmodule

// File: rtl/totient_by_trial_division_unit.sv
// Top level: Euler totient by trial division, sequenced over a shared divider.
//
// One number is taken at a time; req_stall stays high until its totient has
// moved into the result register. Every step is one division by the shared
// restoring divider. The number of divisions is about one per trial divisor
// up to sqrt(number), plus two per prime factor found and one per repeated
// factor; inputs 0 and 1 finish in one division, 2 and 3 in two.
// A new number is taken while a finished result still waits for its transfer.
module totient_by_trial_division_unit import tdt_pkg::*; #(
   parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [NUMBER_WIDTH-1:0] rsp_totient
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_DIVL = 6'b000010,
      S_DIVA = 6'b000100,
      S_DIVR = 6'b001000,
      S_DIVF = 6'b010000,
      S_DONE = 6'b100000
   } state_type;

   state_type               state_ff, state_in;
   logic [NUMBER_WIDTH-1:0] left_ff, left_in;
   logic [NUMBER_WIDTH-1:0] acc_ff, acc_in;
   logic [NUMBER_WIDTH-1:0] d_ff, d_in;
   logic                    go_ff, go_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [NUMBER_WIDTH-1:0] rsp_totient_ff, rsp_totient_in;

   tdt_div_status_type      div_status;
   logic [NUMBER_WIDTH-1:0] div_dividend;
   logic [NUMBER_WIDTH-1:0] div_divisor;
   logic [NUMBER_WIDTH-1:0] div_q;
   logic [NUMBER_WIDTH-1:0] div_r;
   logic                    out_free;

   assign div_dividend = (state_ff == S_DIVA || state_ff == S_DIVF) ? acc_ff : left_ff;
   assign div_divisor  = (state_ff == S_DIVF) ? left_ff : d_ff;

   tdt_divider #(
      .WIDTH (NUMBER_WIDTH)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (go_ff),
      .dividend  (div_dividend),
      .divisor   (div_divisor),
      .status    (div_status),
      .quotient  (div_q),
      .remainder (div_r)
   );

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in       = state_ff;
      left_in        = left_ff;
      acc_in         = acc_ff;
      d_in           = d_ff;
      go_in          = 1'b0;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_totient_in = rsp_totient_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               left_in  = req_number;
               acc_in   = req_number;
               d_in     = NUMBER_WIDTH'(2);
               go_in    = 1'b1;
               state_in = S_DIVL;
            end
         end
         S_DIVL: begin
            if (div_status.done) begin
               priority if (d_ff > div_q) begin
                  if (left_ff > NUMBER_WIDTH'(1)) begin
                     go_in    = 1'b1;
                     state_in = S_DIVF;
                  end else begin
                     state_in = S_DONE;
                  end
               end else if (div_r != '0) begin
                  d_in  = d_ff + 1'b1;
                  go_in = 1'b1;
               end else begin
                  left_in  = div_q;
                  go_in    = 1'b1;
                  state_in = S_DIVA;
               end
            end
         end
         S_DIVA: begin
            if (div_status.done) begin
               acc_in   = acc_ff - div_q;
               go_in    = 1'b1;
               state_in = S_DIVR;
            end
         end
         S_DIVR: begin
            if (div_status.done) begin
               go_in = 1'b1;
               if (div_r == '0) begin
                  left_in = div_q;
               end else begin
                  d_in     = d_ff + 1'b1;
                  state_in = S_DIVL;
               end
            end
         end
         S_DIVF: begin
            if (div_status.done) begin
               acc_in   = acc_ff - div_q;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_totient_in = acc_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      left_ff        <= left_in;
      acc_ff         <= acc_in;
      d_ff           <= d_in;
      rsp_totient_ff <= rsp_totient_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         go_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         go_ff        <= go_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_totient = rsp_totient_ff;

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE))
      else $error("result loaded outside completion");

   a_divisor_floor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVL || state_ff == S_DIVA || state_ff == S_DIVR)
         |-> (d_ff >= NUMBER_WIDTH'(2)))
      else $error("trial divisor below two");

   a_acc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVA || state_ff == S_DIVR) |-> (acc_ff != '0))
      else $error("totient accumulator collapsed mid factor");

endmodule
